// File: hdl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment driver package
// Types, constants and the glyph lookup shared by the display driver files.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

  // Number of digit fields on the result item.
  localparam int OUT_DIGITS = 6;
  // Width of one digit symbol (a nibble) and of one segment byte.
  localparam int SYM_W      = 4;
  localparam int SEG_W      = 8;
  localparam int VALUE_W    = 32;
  localparam int POINTS_W   = 6;

  // Reciprocal of ten for a 32-bit dividend: q = (v * RECIP_10) >> RECIP_SHIFT.
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Display modes carried in tuser.
  localparam logic MODE_HEX = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  // Segment patterns for 0 to F, segment a in bit 0 up to segment g in bit 6.
  localparam logic [6:0] GLYPH [16] = '{
    7'd63,  7'd6,   7'd91,  7'd79,  7'd102, 7'd109, 7'd125, 7'd7,
    7'd127, 7'd111, 7'd119, 7'd124, 7'd57,  7'd94,  7'd121, 7'd113
  };

  // Control that travels alongside each item through the conversion stages.
  typedef struct packed {
    logic                valid;
    logic                mode;
    logic [POINTS_W-1:0] points;
  } ctl_t;

  function automatic logic [6:0] glyph(input logic [SYM_W-1:0] sym);
    glyph = GLYPH[sym];
  endfunction

endpackage

`default_nettype wire

// File: hdl/ssd_stage.sv
// ----------------------------------------------------------------------------
// Digit extraction stage
// Takes one digit off the running value per cycle while en is high: a nibble in
// hex mode, or a decimal digit via reciprocal multiplication in decimal mode.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_stage #(
  parameter int SYMS_W    = 24,
  parameter int DIGIT_IDX = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire ssd_pkg::ctl_t                ctl_in,
  input  wire logic [ssd_pkg::VALUE_W-1:0]  rest_in,
  input  wire logic [SYMS_W-1:0]            syms_in,
  output ssd_pkg::ctl_t                     ctl_out,
  output logic [ssd_pkg::VALUE_W-1:0]       rest_out,
  output logic [SYMS_W-1:0]                 syms_out
);

  localparam int QW = 2 * ssd_pkg::VALUE_W - ssd_pkg::RECIP_SHIFT;

  logic [2*ssd_pkg::VALUE_W-1:0] prod;
  logic [QW-1:0]                 quot;
  logic [ssd_pkg::VALUE_W-1:0]   quot_x10;
  logic [ssd_pkg::VALUE_W-1:0]   remainder;
  logic [ssd_pkg::SYM_W-1:0]     sym;
  logic [ssd_pkg::VALUE_W-1:0]   rest_next;
  logic [SYMS_W-1:0]             syms_next;

  // Divide by ten: exact for every 32-bit dividend with this reciprocal.
  assign prod      = {{ssd_pkg::VALUE_W{1'b0}}, rest_in} *
                     {{ssd_pkg::VALUE_W{1'b0}}, ssd_pkg::RECIP_10};
  assign quot      = prod[2*ssd_pkg::VALUE_W-1:ssd_pkg::RECIP_SHIFT];
  assign quot_x10  = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign remainder = rest_in - quot_x10;

  // Select the digit and the remaining value by mode.
  always_comb begin
    if (ctl_in.mode == ssd_pkg::MODE_DEC) begin
      sym       = remainder[ssd_pkg::SYM_W-1:0];
      rest_next = {{(ssd_pkg::VALUE_W-QW){1'b0}}, quot};
    end else begin
      sym       = rest_in[ssd_pkg::SYM_W-1:0];
      rest_next = {{ssd_pkg::SYM_W{1'b0}}, rest_in[ssd_pkg::VALUE_W-1:ssd_pkg::SYM_W]};
    end
    syms_next = syms_in;
    syms_next[DIGIT_IDX*ssd_pkg::SYM_W +: ssd_pkg::SYM_W] = sym;
  end

  // The valid bit advances with the pipeline and is cleared by reset; the
  // payload registers load only when a valid item moves in.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en && ctl_in.valid) begin
      ctl_out.mode   <= ctl_in.mode;
      ctl_out.points <= ctl_in.points;
      rest_out       <= rest_next;
      syms_out       <= syms_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/seven_segment_hex_decimal_driver.sv
// Path: the input register, the digit extraction stages and then the output register.
// Throughput: one item per cycle; each shown digit has its own divide-by-ten stage,
// so the pipeline holds one item per stage and stalls as a whole on tready.
// Reset: synchronous; clears every stage valid bit and the output valid.
// ----------------------------------------------------------------------------
// Seven-segment hex/decimal display driver
// Converts a value into six digit segment bytes, as hex nibbles or as decimal
// digits, with per-digit decimal points.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_hex_decimal_driver #(
  parameter int DIGIT_COUNT = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // value[31:0], points[37:32], zero pad
  input  wire logic [0:0]  s_axis_tuser,  // operation[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata   // digit0_segments[7:0] .. digit5_segments[47:40]
);

  localparam int NSTAGE = (DIGIT_COUNT < ssd_pkg::OUT_DIGITS) ? DIGIT_COUNT
                                                              : ssd_pkg::OUT_DIGITS;
  localparam int SYMS_W = NSTAGE * ssd_pkg::SYM_W;
  localparam int OUT_W  = ssd_pkg::OUT_DIGITS * ssd_pkg::SEG_W;
  localparam logic [OUT_W-1:0] BLANK_MASK =
    (NSTAGE >= ssd_pkg::OUT_DIGITS) ? '0
                                    : ~((OUT_W'(1) << (ssd_pkg::SEG_W * NSTAGE)) - OUT_W'(1));

  ssd_pkg::ctl_t                 ctl  [NSTAGE+1];
  logic [ssd_pkg::VALUE_W-1:0]   rest [NSTAGE+1];
  logic [SYMS_W-1:0]             syms [NSTAGE+1];
  ssd_pkg::ctl_t                 in_ctl;
  logic [ssd_pkg::VALUE_W-1:0]   in_rest;
  logic                          adv;
  logic [OUT_W-1:0]              seg_next;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_ctl.valid <= 1'b0;
    end else if (adv) begin
      in_ctl.valid <= s_axis_tvalid;
    end
    if (adv && s_axis_tvalid) begin
      in_ctl.mode   <= s_axis_tuser[0];
      in_ctl.points <= s_axis_tdata[ssd_pkg::VALUE_W +: ssd_pkg::POINTS_W];
      in_rest       <= s_axis_tdata[ssd_pkg::VALUE_W-1:0];
    end
  end

  assign ctl[0]  = in_ctl;
  assign rest[0] = in_rest;
  assign syms[0] = '0;

  // One digit extraction stage per shown digit.
  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    ssd_stage #(
      .SYMS_W    (SYMS_W),
      .DIGIT_IDX (k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .ctl_in   (ctl[k]),
      .rest_in  (rest[k]),
      .syms_in  (syms[k]),
      .ctl_out  (ctl[k+1]),
      .rest_out (rest[k+1]),
      .syms_out (syms[k+1])
    );
  end

  // Glyph lookup and decimal points; digits beyond the count stay blank.
  for (genvar j = 0; j < ssd_pkg::OUT_DIGITS; j++) begin : g_seg
    if (j < NSTAGE) begin : g_on
      assign seg_next[j*ssd_pkg::SEG_W +: ssd_pkg::SEG_W] = {
        ctl[NSTAGE].points[j],
        ssd_pkg::glyph(syms[NSTAGE][j*ssd_pkg::SYM_W +: ssd_pkg::SYM_W])
      };
    end else begin : g_off
      assign seg_next[j*ssd_pkg::SEG_W +: ssd_pkg::SEG_W] = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= ctl[NSTAGE].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl[NSTAGE].valid) begin
      m_axis_tdata <= seg_next;
    end
  end

  // A held result must block new items from entering.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // Nothing leaves the block in the cycle after reset.
  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // Digits above the configured count are always blank.
  a_blank_upper_digits: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata & BLANK_MASK) == '0)
    else $error("unused digit not blank");

  // A stalled output stage also freezes the last conversion stage.
  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(ctl[NSTAGE].valid))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// File: tb/seven_segment_hex_decimal_driver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment hex/decimal driver testbench
// Streams display items into the driver and checks every segment byte against
// a behavioural model of the glyph decoding. It runs directed corner values,
// a long random mix, a long output stall and a drain pause, with random gaps
// on both sides of the stream.
// ----------------------------------------------------------------------------

module seven_segment_hex_decimal_driver_tb;

  localparam int DIGITS      = 6;
  localparam int LATENCY     = (DIGITS < ssd_pkg::OUT_DIGITS ? DIGITS
                                                             : ssd_pkg::OUT_DIGITS) + 1;
  localparam int MAX_PRINTED = 25;

  typedef logic [ssd_pkg::OUT_DIGITS-1:0][ssd_pkg::SEG_W-1:0] digit_bytes_t;

  // One display item together with the segment bytes it should produce.
  typedef struct {
    logic                         mode;
    logic [ssd_pkg::VALUE_W-1:0]  value;
    logic [ssd_pkg::POINTS_W-1:0] points;
    digit_bytes_t                 digits;
  } display_case_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  display_case_t pending_digits[$];
  int            src_gap_max = 0;
  int            sink_max    = 0;
  logic          sink_hold   = 1'b0;
  int            sink_wait   = 0;
  int            mismatch_count  = 0;
  int            results_checked = 0;
  int            hex_items = 0;
  int            dec_items = 0;

  seven_segment_hex_decimal_driver #(.DIGIT_COUNT(DIGITS)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // Segment pattern for one symbol, segment a in bit 0 up to segment g in bit 6.
  function automatic logic [6:0] font_of(input logic [3:0] sym);
    case (sym)
      4'h0: font_of = 7'd63;
      4'h1: font_of = 7'd6;
      4'h2: font_of = 7'd91;
      4'h3: font_of = 7'd79;
      4'h4: font_of = 7'd102;
      4'h5: font_of = 7'd109;
      4'h6: font_of = 7'd125;
      4'h7: font_of = 7'd7;
      4'h8: font_of = 7'd127;
      4'h9: font_of = 7'd111;
      4'hA: font_of = 7'd119;
      4'hB: font_of = 7'd124;
      4'hC: font_of = 7'd57;
      4'hD: font_of = 7'd94;
      4'hE: font_of = 7'd121;
      default: font_of = 7'd113;
    endcase
  endfunction

  // Expected segment bytes: nibbles in hex mode, decimal digits otherwise.
  // Digits beyond the configured count stay blank with the point off.
  function automatic digit_bytes_t predict_segments(
      input logic mode,
      input logic [ssd_pkg::VALUE_W-1:0] value,
      input logic [ssd_pkg::POINTS_W-1:0] points);
    digit_bytes_t                segs;
    logic [ssd_pkg::VALUE_W-1:0] rest;
    logic [3:0]                  sym;
    segs = '0;
    rest = value;
    for (int i = 0; i < DIGITS && i < ssd_pkg::OUT_DIGITS; i++) begin
      if (mode == ssd_pkg::MODE_HEX) begin
        sym  = rest[3:0];
        rest = rest >> 4;
      end else begin
        sym  = 4'(rest % 10);
        rest = rest / 10;
      end
      segs[i] = {points[i], font_of(sym)};
    end
    return segs;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Offers one item after a random gap and records its expectation once taken.
  task automatic send_display_item(input logic mode,
                                   input logic [ssd_pkg::VALUE_W-1:0] value,
                                   input logic [ssd_pkg::POINTS_W-1:0] points);
    int            gap;
    display_case_t entry;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, points, value};
    s_axis_tuser  <= mode;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    entry.mode   = mode;
    entry.value  = value;
    entry.points = points;
    entry.digits = predict_segments(mode, value, points);
    pending_digits.push_back(entry);
    if (mode == ssd_pkg::MODE_HEX) hex_items++;
    else dec_items++;
  endtask

  // Stops offering and waits until every expected result has been taken.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  // Corner values, all sixteen glyphs, wrapping and a mix of point patterns.
  task automatic test_directed();
    src_gap_max = 2;
    sink_max    = 2;
    send_display_item(ssd_pkg::MODE_HEX, 32'h0000_0000, 6'h00);
    send_display_item(ssd_pkg::MODE_HEX, 32'hFFFF_FFFF, 6'h3F);
    send_display_item(ssd_pkg::MODE_HEX, 32'h0054_3210, 6'h15);
    send_display_item(ssd_pkg::MODE_HEX, 32'h00BA_9876, 6'h2A);
    send_display_item(ssd_pkg::MODE_HEX, 32'h00FE_DCBA, 6'h01);
    send_display_item(ssd_pkg::MODE_HEX, 32'h89AB_CDEF, 6'h20);
    send_display_item(ssd_pkg::MODE_HEX, 32'hFF00_0000, 6'h3F);
    send_display_item(ssd_pkg::MODE_HEX, 32'h0012_3456, 6'h04);
    send_display_item(ssd_pkg::MODE_DEC, 32'd0, 6'h00);
    send_display_item(ssd_pkg::MODE_DEC, 32'd999999, 6'h3F);
    send_display_item(ssd_pkg::MODE_DEC, 32'd1000000, 6'h02);
    send_display_item(ssd_pkg::MODE_DEC, 32'hFFFF_FFFF, 6'h10);
    send_display_item(ssd_pkg::MODE_DEC, 32'd123456, 6'h08);
    send_display_item(ssd_pkg::MODE_DEC, 32'd789012, 6'h15);
    send_display_item(ssd_pkg::MODE_DEC, 32'd9, 6'h2A);
    send_display_item(ssd_pkg::MODE_DEC, 32'd10, 6'h01);
    send_display_item(ssd_pkg::MODE_DEC, 32'd1999999999, 6'h00);
    send_display_item(ssd_pkg::MODE_DEC, 32'd1000000000, 6'h3F);
    send_display_item(ssd_pkg::MODE_DEC, 32'd4294000000, 6'h20);
    send_display_item(ssd_pkg::MODE_HEX, 32'h0000_000F, 6'h00);
    wait_for_drain();
  endtask

  // Random modes, values and points, in chunks with different idling.
  task automatic test_random_mix(input int chunks);
    logic [ssd_pkg::VALUE_W-1:0] val;
    logic [ssd_pkg::VALUE_W-1:0] pow10;
    for (int c = 0; c < chunks; c++) begin
      case ($urandom_range(0, 2))
        0: src_gap_max = 0;
        1: src_gap_max = 3;
        default: src_gap_max = 16;
      endcase
      case ($urandom_range(0, 2))
        0: sink_max = 0;
        1: sink_max = 3;
        default: sink_max = 16;
      endcase
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 5))
          0: val = $urandom();
          1: val = $urandom_range(0, 999999);
          2: begin
            pow10 = 1;
            repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
            val = pow10 + $urandom_range(0, 2) - 1;
          end
          3: val = {8{4'($urandom_range(0, 15))}};
          4: val = $urandom_range(0, 15);
          default: val = 32'hFFFF_FFFF - $urandom_range(0, 1000);
        endcase
        send_display_item(1'($urandom_range(0, 1)), val, 6'($urandom_range(0, 63)));
      end
    end
    wait_for_drain();
  endtask

  // The receiver stops for a long stretch while items keep coming, so the
  // pipeline fills and holds its input off.
  task automatic test_output_stall();
    src_gap_max = 0;
    sink_max    = 0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (60) @(posedge clk);
        sink_hold <= 1'b0;
      end
      begin
        for (int n = 0; n < 40; n++)
          send_display_item(1'($urandom_range(0, 1)), $urandom(), 6'($urandom_range(0, 63)));
        wait_for_drain();
      end
    join
  endtask

  // The sender pauses until the block has emptied, then resumes.
  task automatic test_drain_pause();
    src_gap_max = 4;
    sink_max    = 4;
    for (int n = 0; n < 25; n++)
      send_display_item(1'($urandom_range(0, 1)), $urandom(), 6'($urandom_range(0, 63)));
    wait_for_drain();
    for (int n = 0; n < 25; n++)
      send_display_item(1'($urandom_range(0, 1)), $urandom(), 6'($urandom_range(0, 63)));
    wait_for_drain();
  endtask

  // Receiver ready: a random stall after each result, or a forced hold.
  always @(posedge clk) begin : sink_ctl
    int draw;
    if (m_axis_tvalid && m_axis_tready) draw = $urandom_range(0, sink_max);
    else draw = sink_wait;
    if (sink_hold || draw > 0) m_axis_tready <= 1'b0;
    else m_axis_tready <= 1'b1;
    sink_wait <= (draw > 0 && !sink_hold) ? draw - 1 : draw;
  end

  // Compare each result, digit by digit, with the oldest expectation.
  always @(posedge clk) begin : result_check
    display_case_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_digits.size() == 0) begin
        report_mismatch($sformatf("result 0x%012h with no item outstanding", m_axis_tdata));
      end else begin
        want = pending_digits.pop_front();
        results_checked++;
        for (int d = 0; d < ssd_pkg::OUT_DIGITS; d++) begin
          if (m_axis_tdata[ssd_pkg::SEG_W*d +: ssd_pkg::SEG_W] !== want.digits[d])
            report_mismatch($sformatf(
              "digit%0d mode %0d value 0x%08h points 0x%02h: got 0x%02h want 0x%02h",
              d, want.mode, want.value, want.points,
              m_axis_tdata[ssd_pkg::SEG_W*d +: ssd_pkg::SEG_W], want.digits[d]));
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix(11);
    test_output_stall();
    test_drain_pause();
    wait_for_drain();
    repeat (LATENCY + 4) @(posedge clk);
    $display("Covered %0d hex and %0d decimal items, %0d results checked,",
             hex_items, dec_items, results_checked);
    $display("including a long output stall and a full drain pause; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0 && pending_digits.size() == 0) begin
      $display("seven_segment_hex_decimal_driver_tb passed");
    end else begin
      $display("seven_segment_hex_decimal_driver_tb failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding.", pending_digits.size());
    $display("seven_segment_hex_decimal_driver_tb failed");
    $finish;
  end

endmodule
